>>> rtl/core/itda_pkg.sv
// shared constants and types for the integer to decimal text converter
package itda_pkg;

	localparam int NumDigits  = 10;
	localparam int DigitWidth = 4;
	localparam int ValueWidth = 32;

	typedef logic [DigitWidth-1:0] digit_t;

	typedef struct packed {
		logic clear;
		logic shift_bit;
		logic shift_digit;
	} chain_ctrl_t;

endpackage

>>> rtl/core/int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii characters
// Takes one signed 32-bit value per transaction and returns its decimal text one character per
// output transaction, most significant first, with a leading minus for negative values, no
// leading zeros, and last set on the final character. Each item is accepted, its magnitude is
// shifted bit by bit through the ten-cell shift-add-3 digit chain, then leading zero digits are
// dropped one digit position at a time until the top digit is nonzero or one digit is left, and
// the minus sign (for negative values) and the significant digits are emitted. No new value is taken meanwhile.
module int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  character,
	output logic        last
);
	import itda_pkg::*;

	localparam logic [5:0] AsciiZero  = 6'd48;
	localparam logic [5:0] AsciiMinus = 6'd45;
	localparam int         CntWidth   = $clog2(ValueWidth);
	localparam int         RemWidth   = $clog2(NumDigits + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SKIP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [ValueWidth-1:0]  mag_q;
	logic                   neg_q;
	logic [CntWidth-1:0]    cnt_q;
	logic [RemWidth-1:0]    remain_q;
	logic                   out_valid_q;
	logic [5:0]             character_q;
	logic                   last_q;

	chain_ctrl_t            ctrl;
	digit_t                 top_digit;
	logic                   overflow;
	logic                   slot_free;
	logic                   emit_digit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

	assign slot_free  = !out_valid_q || out_ready;
	assign emit_digit = (state_q == ST_EMIT) && slot_free && !neg_q;

	always_comb begin
		ctrl.clear       = in_valid && in_ready;
		ctrl.shift_bit   = (state_q == ST_CONV);
		ctrl.shift_digit = emit_digit ||
			((state_q == ST_SKIP) && (top_digit == '0) && (remain_q > RemWidth'(1)));
	end

	itda_bcd_chain u_chain (
		.clk       (clk),
		.ctrl      (ctrl),
		.bit_in    (mag_q[ValueWidth-1]),
		.top_digit (top_digit),
		.overflow  (overflow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			neg_q    <= 1'b0;
			cnt_q    <= '0;
			remain_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						neg_q   <= value[ValueWidth-1];
						cnt_q   <= '0;
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CntWidth'(1);
					if (cnt_q == CntWidth'(ValueWidth - 1)) begin
						remain_q <= RemWidth'(NumDigits);
						state_q  <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (ctrl.shift_digit) begin
						remain_q <= remain_q - RemWidth'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (neg_q) begin
							neg_q <= 1'b0;
						end else begin
							remain_q <= remain_q - RemWidth'(1);
							if (remain_q == RemWidth'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// magnitude shift register, most negative value wraps to its own magnitude
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mag_q <= value[ValueWidth-1] ? (~value + ValueWidth'(1)) : value;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[ValueWidth-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && slot_free) begin
			if (neg_q) begin
				character_q <= AsciiMinus;
				last_q      <= 1'b0;
			end else begin
				character_q <= AsciiZero + {2'b00, top_digit};
				last_q      <= (remain_q == RemWidth'(1));
			end
		end
	end

	// ten digits always hold a 32-bit magnitude
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !overflow)
		else $error("digit chain overflow");

	a_remain_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> (remain_q != '0))
		else $error("digit count exhausted while emitting");

	// the first emitted digit is never a leading zero
	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP && !ctrl.shift_digit) |->
			(top_digit != '0 || remain_q == RemWidth'(1)))
		else $error("leading zero reached the output");

endmodule

>>> rtl/core/itda_bcd_cell.sv
// one decimal digit cell of the shift-add-3 chain
module itda_bcd_cell (
	input  logic                 clk,
	input  itda_pkg::chain_ctrl_t ctrl,
	input  logic                 carry_in,
	input  itda_pkg::digit_t     digit_in,
	output logic                 carry_out,
	output itda_pkg::digit_t     digit
);
	import itda_pkg::*;

	digit_t digit_q;
	digit_t adjusted;

	assign adjusted  = (digit_q >= digit_t'(5)) ? digit_q + digit_t'(3) : digit_q;
	assign carry_out = adjusted[DigitWidth-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.shift_bit) begin
			digit_q <= {adjusted[DigitWidth-2:0], carry_in};
		end else if (ctrl.shift_digit) begin
			digit_q <= digit_in;
		end
	end

endmodule

>>> rtl/core/itda_bcd_chain.sv
// row of digit cells, bits enter at the least significant cell
module itda_bcd_chain (
	input  logic                  clk,
	input  itda_pkg::chain_ctrl_t ctrl,
	input  logic                  bit_in,
	output itda_pkg::digit_t      top_digit,
	output logic                  overflow
);
	import itda_pkg::*;

	logic   [NumDigits:0] carry;
	digit_t               digits [NumDigits];

	assign carry[0] = bit_in;

	for (genvar i = 0; i < NumDigits; i++) begin : g_cell
		digit_t lower;
		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_rest
			assign lower = digits[i-1];
		end
		itda_bcd_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.carry_in  (carry[i]),
			.digit_in  (lower),
			.carry_out (carry[i+1]),
			.digit     (digits[i])
		);
	end

	assign top_digit = digits[NumDigits-1];
	assign overflow  = carry[NumDigits];

endmodule
